// ===== hw/rtl/bss_pkg.sv =====
// ----------------------------------------------------------------------------
// bss_pkg
// Types and constants shared by the byte substring search block: transaction
// payload structs, function codes and position limits.
// ----------------------------------------------------------------------------
package bss_pkg;

   localparam int POS_WIDTH = 31;
   localparam int POS_OUT_WIDTH = 32;

   localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};
   localparam logic [POS_WIDTH-1:0] POS_ONE = POS_WIDTH'(1);
   localparam logic [POS_WIDTH-1:0] START_RESET = POS_WIDTH'(1);
   localparam logic signed [POS_OUT_WIDTH-1:0] POS_NONE = '1;

   localparam logic [1:0] FUNC_PATTERN = 2'd0;
   localparam logic [1:0] FUNC_TEXT = 2'd1;
   localparam logic [1:0] FUNC_END = 2'd2;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic found;
      logic signed [POS_OUT_WIDTH-1:0] match_position;
      logic pattern_overflow;
   } rsp_payload_type;

endpackage

// ===== hw/rtl/byte_substring_search_top.sv =====
// ----------------------------------------------------------------------------
// byte_substring_search_top
// First-occurrence search of a byte pattern in a streamed byte text.
// ----------------------------------------------------------------------------
// Pattern bytes are loaded first, then text bytes stream in, then an end
// transaction returns one result: the 1-based position of the first match at
// or after csr_data's start position, or -1. A new request is accepted each
// cycle while the result register is free or being drained. The pattern and
// the last MAX_PATTERN text bytes sit in two shift registers, so each text
// byte is checked against the whole pattern in the cycle it is accepted. The
// end transaction's result appears on the next cycle and clears the search;
// start_position is kept.
module byte_substring_search_top #(
   parameter int MAX_PATTERN = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  bss_pkg::req_payload_type        req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output bss_pkg::rsp_payload_type        rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bss_pkg::POS_WIDTH-1:0]   csr_data
);
   import bss_pkg::*;

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);

   logic [7:0]           pattern_ff [MAX_PATTERN];
   logic [7:0]           pattern_in [MAX_PATTERN];
   logic [7:0]           window_ff [MAX_PATTERN];
   logic [7:0]           window_in [MAX_PATTERN];
   logic [7:0]           window_shift [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] hit_vec;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic                 overflow_ff, overflow_in;
   logic [POS_WIDTH-1:0] count_ff, count_in;
   logic                 seen_ff, seen_in;
   logic [POS_WIDTH-1:0] first_ff, first_in;
   logic [POS_WIDTH-1:0] start_ff, start_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_data_ff, rsp_data_in;
   logic                 req_fire;
   logic                 all_match;
   logic [POS_WIDTH-1:0] count_inc;
   logic [POS_WIDTH-1:0] pos;
   logic [POS_WIDTH-1:0] start_eff;
   logic                 hit;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign req_fire = req_valid && req_ready;

   always_comb begin
      window_shift[0] = req_data.data_byte;
      for (int j = 1; j < MAX_PATTERN; j++) begin
         window_shift[j] = window_ff[j-1];
      end
      for (int j = 0; j < MAX_PATTERN; j++) begin
         hit_vec[j] = (LEN_W'(j) >= len_ff) || (pattern_ff[j] == window_shift[j]);
      end
      all_match = &hit_vec;
      count_inc = count_ff + POS_ONE;
      pos = count_inc - POS_WIDTH'(len_ff) + POS_ONE;
      start_eff = (start_ff <= POS_ONE) ? POS_ONE : start_ff;
      hit = seen_ff && !overflow_ff;
   end

   always_comb begin
      pattern_in = pattern_ff;
      window_in = window_ff;
      len_in = len_ff;
      overflow_in = overflow_ff;
      count_in = count_ff;
      seen_in = seen_ff;
      first_in = first_ff;
      start_in = csr_valid ? csr_data : start_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      if (req_fire) begin
         unique case (req_data.func)
            FUNC_PATTERN: begin
               if (len_ff < LEN_W'(MAX_PATTERN)) begin
                  pattern_in[0] = req_data.data_byte;
                  for (int j = 1; j < MAX_PATTERN; j++) begin
                     pattern_in[j] = pattern_ff[j-1];
                  end
                  len_in = len_ff + LEN_W'(1);
               end else begin
                  overflow_in = 1'b1;
               end
            end
            FUNC_TEXT: begin
               if (count_ff != POS_MAX) begin
                  window_in = window_shift;
                  count_in = count_inc;
                  if (!seen_ff && !overflow_ff && (len_ff != '0) &&
                      (count_inc >= POS_WIDTH'(len_ff)) && (pos >= start_eff) &&
                      all_match) begin
                     seen_in = 1'b1;
                     first_in = pos;
                  end
               end
            end
            FUNC_END: begin
               rsp_valid_in = 1'b1;
               rsp_data_in.found = hit;
               rsp_data_in.match_position = hit ? {1'b0, first_ff} : POS_NONE;
               rsp_data_in.pattern_overflow = overflow_ff;
               len_in = '0;
               overflow_in = 1'b0;
               count_in = '0;
               seen_in = 1'b0;
               first_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         overflow_ff <= 1'b0;
         count_ff <= '0;
         seen_ff <= 1'b0;
         start_ff <= START_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff <= len_in;
         overflow_ff <= overflow_in;
         count_ff <= count_in;
         seen_ff <= seen_in;
         start_ff <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pattern_ff <= pattern_in;
      window_ff <= window_in;
      first_ff <= first_in;
      rsp_data_ff <= rsp_data_in;
   end

   // end transaction always yields a result on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_data.func == FUNC_END) |=> rsp_valid)
      else $error("end transaction produced no result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |->
         !rsp_data.pattern_overflow && !rsp_data.match_position[POS_OUT_WIDTH-1] &&
         (rsp_data.match_position != '0))
      else $error("found result with bad position or overflow");

   assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MAX_PATTERN))
      else $error("pattern length beyond store depth");

   assert property (@(posedge clock) disable iff (reset)
      seen_ff |-> (first_ff != '0) && (first_ff <= count_ff))
      else $error("kept match position outside text seen so far");

endmodule

// ===== dv/byte_substring_search_top_tb.sv =====
// ----------------------------------------------------------------------------
// byte_substring_search_top_tb
// Self-checking bench for the first-occurrence byte substring search. Short
// directed searches come first. Then random searches run under several start
// positions, with random bursts of idling on the request and result sides.
// A predictor tracks the pattern, the text window and the start position. It
// checks every result transaction against the oldest expected report.
// ----------------------------------------------------------------------------
module byte_substring_search_top_tb;
   import bss_pkg::*;

   localparam int PATTERN_DEPTH = 32;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 4;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [POS_WIDTH-1:0] csr_data = '0;

   // search predictor state
   logic [7:0] pat_bytes [PATTERN_DEPTH];
   int unsigned pat_len;
   bit pat_overflow;
   logic [7:0] window_bytes [PATTERN_DEPTH];
   logic [POS_WIDTH-1:0] text_seen;
   bit hit_seen;
   logic [POS_WIDTH-1:0] hit_pos;
   logic [POS_WIDTH-1:0] start_model = START_RESET;
   rsp_payload_type expected_reports [$];

   int error_count = 0;
   int reports_checked = 0;
   int items_sent = 0;
   int hits_checked = 0;
   int overflows_checked = 0;
   int cycle_count = 0;
   int req_gap_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_stall_left = 0;

   byte_substring_search_top #(
      .MAX_PATTERN(PATTERN_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void clear_search_model();
      int k;
      pat_len = 0;
      pat_overflow = 1'b0;
      for (k = 0; k < PATTERN_DEPTH; k++) window_bytes[k] = 8'h00;
      text_seen = '0;
      hit_seen = 1'b0;
      hit_pos = '0;
   endfunction

   function automatic void predict_search(input req_payload_type item);
      logic [POS_WIDTH-1:0] pos;
      logic [POS_WIDTH-1:0] first_pos;
      bit same;
      int k;
      rsp_payload_type report;
      case (item.func)
         FUNC_PATTERN: begin
            if (pat_len < PATTERN_DEPTH) begin
               pat_bytes[pat_len] = item.data_byte;
               pat_len++;
            end else begin
               pat_overflow = 1'b1;
            end
         end
         FUNC_TEXT: begin
            if (text_seen != POS_MAX) begin
               for (k = 0; k < PATTERN_DEPTH - 1; k++) window_bytes[k] = window_bytes[k + 1];
               window_bytes[PATTERN_DEPTH - 1] = item.data_byte;
               text_seen++;
               if (!hit_seen && !pat_overflow && pat_len != 0 && text_seen >= pat_len) begin
                  pos = text_seen - POS_WIDTH'(pat_len) + POS_ONE;
                  first_pos = (start_model <= POS_ONE) ? POS_ONE : start_model;
                  same = 1'b1;
                  for (k = 0; k < pat_len; k++) begin
                     if (window_bytes[PATTERN_DEPTH - pat_len + k] != pat_bytes[k]) same = 1'b0;
                  end
                  if (pos >= first_pos && same) begin
                     hit_seen = 1'b1;
                     hit_pos = pos;
                  end
               end
            end
         end
         FUNC_END: begin
            report.found = hit_seen && !pat_overflow;
            report.match_position = report.found ? {1'b0, hit_pos} : POS_NONE;
            report.pattern_overflow = pat_overflow;
            expected_reports.push_back(report);
            clear_search_model();
         end
         default: begin
         end
      endcase
   endfunction

   // result check first, then request prediction, all at the same edge
   always @(posedge clock) begin
      rsp_payload_type exp_report;
      if (reset) begin
         clear_search_model();
         start_model = START_RESET;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $error("unexpected result transaction: %p", rsp_data);
               error_count++;
            end else begin
               exp_report = expected_reports.pop_front();
               reports_checked++;
               if (exp_report.found) hits_checked++;
               if (exp_report.pattern_overflow) overflows_checked++;
               if (rsp_data.found !== exp_report.found) begin
                  $error("found: expected %0d, actual %0d", exp_report.found, rsp_data.found);
                  error_count++;
               end
               if (rsp_data.match_position !== exp_report.match_position) begin
                  $error("match_position: expected %0d, actual %0d",
                         exp_report.match_position, rsp_data.match_position);
                  error_count++;
               end
               if (rsp_data.pattern_overflow !== exp_report.pattern_overflow) begin
                  $error("pattern_overflow: expected %0d, actual %0d",
                         exp_report.pattern_overflow, rsp_data.pattern_overflow);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) predict_search(req_data);
         if (csr_valid && csr_ready) start_model = csr_data;
      end
   end

   always @(posedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_stall_left--;
      end else if (rsp_stall_pct != 0 && $urandom_range(99) < rsp_stall_pct) begin
         rsp_stall_left = $urandom_range(12, 1);
      end
      rsp_ready <= (rsp_stall_left == 0);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_item(input logic [1:0] func_code, input logic [7:0] value);
      if (req_gap_pct != 0 && $urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(12, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{func: func_code, data_byte: value};
      do @(posedge clock); while (!req_ready);
      if (func_code != FUNC_UNUSED) items_sent++;
   endtask

   task automatic settle_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_start_position(input logic [POS_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] symbol_byte(input int alphabet);
      if (alphabet > 4) return 8'($urandom_range(255));
      case ($urandom_range(alphabet - 1))
         0: return 8'h00;
         1: return 8'hff;
         2: return 8'h3c;
         default: return 8'hc3;
      endcase
   endfunction

   task automatic test_empty_pattern();
      send_item(FUNC_END, 8'h00);
      send_item(FUNC_TEXT, 8'h00);
      send_item(FUNC_END, 8'hff);
   endtask

   task automatic test_simple_match();
      send_item(FUNC_PATTERN, 8'h00);
      send_item(FUNC_PATTERN, 8'hff);
      send_item(FUNC_TEXT, 8'hff);
      send_item(FUNC_TEXT, 8'h00);
      send_item(FUNC_TEXT, 8'hff);
      send_item(FUNC_TEXT, 8'h00);
      send_item(FUNC_END, 8'h00);
   endtask

   task automatic test_unused_func();
      send_item(FUNC_UNUSED, 8'hff);
      send_item(FUNC_PATTERN, 8'h5a);
      send_item(FUNC_UNUSED, 8'h00);
      send_item(FUNC_TEXT, 8'h5a);
      send_item(FUNC_END, 8'h00);
   endtask

   task automatic test_pattern_after_text();
      send_item(FUNC_PATTERN, 8'h11);
      send_item(FUNC_TEXT, 8'h22);
      send_item(FUNC_PATTERN, 8'h22);
      send_item(FUNC_TEXT, 8'h11);
      send_item(FUNC_TEXT, 8'h22);
      send_item(FUNC_END, 8'h00);
   endtask

   task automatic test_pattern_longer_than_text();
      send_item(FUNC_PATTERN, 8'ha5);
      send_item(FUNC_PATTERN, 8'ha5);
      send_item(FUNC_PATTERN, 8'ha5);
      send_item(FUNC_TEXT, 8'ha5);
      send_item(FUNC_TEXT, 8'ha5);
      send_item(FUNC_END, 8'h00);
   endtask

   // a pattern load, text with planted copies, stray pattern bytes and unused codes, then an end
   task automatic random_search(input int forced_len);
      logic [7:0] pattern_q [$];
      int plen;
      int tlen;
      int alphabet;
      int roll;
      int pos;
      int k;
      alphabet = ($urandom_range(3) == 0) ? 256 : $urandom_range(4, 2);
      roll = $urandom_range(99);
      if (forced_len >= 0) plen = forced_len;
      else if (roll < 5) plen = 0;
      else if (roll < 12) plen = $urandom_range(36, 28);
      else plen = $urandom_range(4, 1);
      for (k = 0; k < plen; k++) begin
         pattern_q.push_back(symbol_byte(alphabet));
         send_item(FUNC_PATTERN, pattern_q[k]);
      end
      tlen = $urandom_range(plen > 8 ? 2 * plen : 20, 0);
      pos = 0;
      while (pos < tlen) begin
         roll = $urandom_range(99);
         if (roll < 3) begin
            send_item(FUNC_UNUSED, 8'($urandom_range(255)));
         end else if (roll < 5) begin
            send_item(FUNC_PATTERN, symbol_byte(alphabet));
         end else if (roll < 20 && plen > 0) begin
            for (k = 0; k < plen; k++) send_item(FUNC_TEXT, pattern_q[k]);
            pos += plen;
         end else begin
            send_item(FUNC_TEXT, symbol_byte(alphabet));
            pos++;
         end
      end
      send_item(FUNC_END, 8'($urandom_range(255)));
   endtask

   task automatic test_random_searches();
      logic [POS_WIDTH-1:0] settings [7];
      int p;
      int budget;
      settings[0] = '0;
      settings[1] = POS_WIDTH'(2);
      settings[2] = POS_MAX;
      settings[3] = POS_WIDTH'($urandom_range(12, 3));
      settings[4] = POS_WIDTH'($urandom);
      settings[5] = POS_ONE;
      settings[6] = POS_WIDTH'($urandom_range(6, 1));
      for (p = 0; p < 7; p++) begin
         settle_idle();
         write_start_position(settings[p]);
         req_gap_pct = (p == 2 || p == 6) ? 0 : $urandom_range(40, 5);
         rsp_stall_pct = (p == 4 || p == 6) ? 0 : $urandom_range(40, 5);
         budget = items_sent + 145;
         random_search(p == 0 ? PATTERN_DEPTH + 1 : (p == 1 ? PATTERN_DEPTH : -1));
         while (items_sent < budget) random_search(-1);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      req_gap_pct = 20;
      rsp_stall_pct = 20;
      test_empty_pattern();
      test_simple_match();
      test_unused_func();
      test_pattern_after_text();
      test_pattern_longer_than_text();
      test_random_searches();
      settle_idle();
      repeat (8) @(posedge clock);
      $display("searched with %0d request transactions, checked %0d reports", items_sent,
               reports_checked);
      $display("reports with a match: %0d, with pattern overflow: %0d", hits_checked,
               overflows_checked);
      if (error_count == 0 && expected_reports.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/bss_pkg.sv
hw/rtl/byte_substring_search_top.sv
dv/byte_substring_search_top_tb.sv
